/* rtl/point_rotate_scale_project_macros.svh */
// Assertion macros for the point transform checker.
// No dependencies; included by the checker file.
`ifndef POINT_ROTATE_SCALE_PROJECT_MACROS_SVH
`define POINT_ROTATE_SCALE_PROJECT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define PRS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point_rotate_scale_project: implication check failed");

// Condition that holds at every rising edge outside reset.
`define PRS_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("point_rotate_scale_project: invariant check failed");

`endif

/* rtl/prs_pkg.sv */
// Shared widths, register codes and the screen mapping function
// for the point transform pipeline. No dependencies.
package prs_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int TRIG_FRAC     = 14;
    localparam int SCALE_FRAC    = 12;
    localparam int OFF_FRAC      = 12;

    localparam int IN_W   = 18;
    localparam int TRIG_W = 16;
    localparam int SCR_W  = 16;

    // Rotation stage widths: products, sums, results.
    localparam int P1_W = IN_W + TRIG_W;
    localparam int S1_W = P1_W + 1;
    localparam int A_W  = S1_W - TRIG_FRAC;
    localparam int P2_W = A_W + TRIG_W;
    localparam int S2_W = P2_W + 1;
    localparam int B_W  = S2_W - TRIG_FRAC;
    localparam int P3_W = B_W + TRIG_W;
    localparam int S3_W = P3_W + 1;
    localparam int C_W  = S3_W - TRIG_FRAC;
    localparam int P4_W = C_W + TRIG_W + 1;
    localparam int SC_W = P4_W - SCALE_FRAC;
    localparam int CW   = SC_W + 2;

    localparam int PD_W = CW + TRIG_W;
    localparam int DW   = PD_W + 2;
    localparam int DMW  = DW - 1;
    localparam int NM_W = CW + SCR_W;
    localparam int NW   = NM_W + TRIG_FRAC;
    localparam int QB   = 18;

    localparam int PIPE_LAT = QB + 14;

    localparam int SCR_MAX = 32767;
    localparam int SCR_MIN = -32768;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSETS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF    = 3'd6;

    localparam logic [31:0] ROT_RST   = 32'd16384;
    localparam logic [15:0] SCALE_RST = 16'd4096;
    localparam logic [47:0] OFFS_RST  = 48'd0;
    localparam logic [15:0] GAIN_RST  = 16'd8192;
    localparam logic [31:0] HALF_RST  = 32'd0;

    typedef struct packed {
        logic              neg;
        logic              zero;
        logic [SCR_W-1:0]  half;
    } t_div_tag;

    // Returns {clip, screen}: half minus the signed quotient, saturated.
    function automatic logic [SCR_W:0] screen_map(input logic ov, input logic neg,
                                                  input logic [QB-1:0] q,
                                                  input logic [SCR_W-1:0] half);
        logic signed [QB:0]   qs;
        logic signed [QB+1:0] s;
        logic [SCR_W:0]       res;
        qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        s  = $signed({{(QB+2-SCR_W){1'b0}}, half}) - (QB+2)'(qs);
        if (ov) begin
            res = neg ? {1'b1, SCR_W'(SCR_MAX)} : {1'b1, SCR_W'(SCR_MIN)};
        end else if (s > SCR_MAX) begin
            res = {1'b1, SCR_W'(SCR_MAX)};
        end else if (s < SCR_MIN) begin
            res = {1'b1, SCR_W'(SCR_MIN)};
        end else begin
            res = {1'b0, s[SCR_W-1:0]};
        end
        return res;
    endfunction

endpackage

/* rtl/prs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow
// flag when the quotient needs more than QB bits. Depends on prs_pkg.
module prs_div
    import prs_pkg::*;
#(
    parameter int N_W = NW,
    parameter int D_W = DMW,
    parameter int Q_W = QB
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  t_div_tag       i_tag,
    output logic           o_valid,
    output logic           o_ov,
    output logic [Q_W-1:0] o_q,
    output t_div_tag       o_tag
);

    localparam int RW = D_W + Q_W;

    logic [RW-1:0]  r_rem [0:Q_W];
    logic [D_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0] r_q   [0:Q_W];
    logic           r_ov  [0:Q_W];
    logic           r_vld [0:Q_W];
    t_div_tag       r_tag [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= {{(RW-N_W){1'b0}}, i_num};
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ov[0]  <= ({i_den, {Q_W{1'b0}}} <= {{(RW-N_W){1'b0}}, i_num});
        r_tag[0] <= i_tag;
    end

    for (genvar gk = 0; gk < Q_W; gk++) begin : g_step
        localparam int SH = Q_W - 1 - gk;
        logic [RW-1:0]  n_dsh;
        logic           n_ge;
        logic [Q_W-1:0] n_q;

        always_comb begin
            n_dsh     = RW'(r_den[gk]) << SH;
            n_ge      = !r_ov[gk] && (r_rem[gk] >= n_dsh);
            n_q       = r_q[gk];
            n_q[SH]   = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gk+1] <= 1'b0;
            end else begin
                r_vld[gk+1] <= r_vld[gk];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[gk+1]     <= n_ge ? (r_rem[gk] - n_dsh) : r_rem[gk];
            r_q[gk+1]       <= n_q;
            r_den[gk+1]     <= r_den[gk];
            r_ov[gk+1]      <= r_ov[gk];
            r_tag[gk+1]     <= r_tag[gk];
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_ov    = r_ov[Q_W];
    assign o_q     = r_q[Q_W];
    assign o_tag   = r_tag[Q_W];

endmodule

/* rtl/point_rotate_scale_project.sv */
// Throughput: one point per cycle; busy is low except during reset and
// the cycle after it. Twelve front stages, the 19-stage dividers (entry
// register plus 18 quotient-bit stages) and the output register set the depth.
// Reset (synchronous, active low) loads the register defaults and drops
// every point in flight. Results cannot be stalled by the receiver.
module point_rotate_scale_project
    import prs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic signed [IN_W-1:0] i_px,
    input  logic signed [IN_W-1:0] i_py,
    input  logic signed [IN_W-1:0] i_pz,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic signed [SCR_W-1:0] o_screen_x,
    output logic signed [SCR_W-1:0] o_screen_y,
    output logic                  o_zero_divisor,
    output logic                  o_clipped
);

    localparam int OFF_SH_L = (FRAC_BITS >= OFF_FRAC) ? FRAC_BITS - OFF_FRAC : 0;
    localparam int OFF_SH_R = (FRAC_BITS >= OFF_FRAC) ? 0 : OFF_FRAC - FRAC_BITS;
    localparam logic signed [DW-1:0] D_ONE = DW'(1) <<< (FRAC_BITS + TRIG_FRAC);

    logic          r_busy;
    logic [31:0]   r_rot_x, r_rot_y, r_rot_z, r_half;
    logic [15:0]   r_scale, r_gain;
    logic [47:0]   r_offs;
    logic [12:1]   r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_x <= ROT_RST;
            r_rot_y <= ROT_RST;
            r_rot_z <= ROT_RST;
            r_scale <= SCALE_RST;
            r_offs  <= OFFS_RST;
            r_gain  <= GAIN_RST;
            r_half  <= HALF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROT_X:   r_rot_x <= i_cfg_data[31:0];
                CFG_ROT_Y:   r_rot_y <= i_cfg_data[31:0];
                CFG_ROT_Z:   r_rot_z <= i_cfg_data[31:0];
                CFG_SCALE:   r_scale <= i_cfg_data[15:0];
                CFG_OFFSETS: r_offs  <= i_cfg_data[47:0];
                CFG_GAIN:    r_gain  <= i_cfg_data[15:0];
                CFG_HALF:    r_half  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic signed [TRIG_W-1:0] xs, xc, ys, yc, zs, zc, gain;
    logic signed [TRIG_W-1:0] off_x, off_y, off_z;
    logic signed [TRIG_W+1:0] scale_s;
    assign xs      = $signed(r_rot_x[31:16]);
    assign xc      = $signed(r_rot_x[15:0]);
    assign ys      = $signed(r_rot_y[31:16]);
    assign yc      = $signed(r_rot_y[15:0]);
    assign zs      = $signed(r_rot_z[31:16]);
    assign zc      = $signed(r_rot_z[15:0]);
    assign gain    = $signed(r_gain);
    assign off_x   = $signed(r_offs[15:0]);
    assign off_y   = $signed(r_offs[31:16]);
    assign off_z   = $signed(r_offs[47:32]);
    assign scale_s = $signed({2'b00, r_scale});

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[11:1], i_start && !r_busy};
        end
    end

    // stage 1: X rotation products
    logic signed [IN_W-1:0] r_x1;
    logic signed [P1_W-1:0] r_p1a, r_p1b, r_p1c, r_p1d;
    always_ff @(posedge i_clk) begin
        r_x1  <= i_px;
        r_p1a <= P1_W'(i_py) * P1_W'(xc);
        r_p1b <= P1_W'(i_pz) * P1_W'(xs);
        r_p1c <= P1_W'(i_py) * P1_W'(xs);
        r_p1d <= P1_W'(i_pz) * P1_W'(xc);
    end

    // stage 2: X rotation round
    logic signed [S1_W-1:0] n_s2y, n_s2z;
    logic signed [IN_W-1:0] r_x2;
    logic signed [A_W-1:0]  r_y2, r_z2;
    assign n_s2y = S1_W'(r_p1a) - S1_W'(r_p1b) + (S1_W'(1) <<< (TRIG_FRAC - 1));
    assign n_s2z = S1_W'(r_p1c) + S1_W'(r_p1d) + (S1_W'(1) <<< (TRIG_FRAC - 1));
    always_ff @(posedge i_clk) begin
        r_x2 <= r_x1;
        r_y2 <= A_W'(n_s2y >>> TRIG_FRAC);
        r_z2 <= A_W'(n_s2z >>> TRIG_FRAC);
    end

    // stage 3: Y rotation products
    logic signed [A_W-1:0]  r_y3;
    logic signed [P2_W-1:0] r_p3a, r_p3b, r_p3c, r_p3d;
    always_ff @(posedge i_clk) begin
        r_y3  <= r_y2;
        r_p3a <= P2_W'(r_x2) * P2_W'(yc);
        r_p3b <= P2_W'(r_z2) * P2_W'(ys);
        r_p3c <= P2_W'(r_z2) * P2_W'(yc);
        r_p3d <= P2_W'(r_x2) * P2_W'(ys);
    end

    // stage 4: Y rotation round
    logic signed [S2_W-1:0] n_s4x, n_s4z;
    logic signed [A_W-1:0]  r_y4;
    logic signed [B_W-1:0]  r_x4, r_z4;
    assign n_s4x = S2_W'(r_p3a) + S2_W'(r_p3b) + (S2_W'(1) <<< (TRIG_FRAC - 1));
    assign n_s4z = S2_W'(r_p3c) - S2_W'(r_p3d) + (S2_W'(1) <<< (TRIG_FRAC - 1));
    always_ff @(posedge i_clk) begin
        r_y4 <= r_y3;
        r_x4 <= B_W'(n_s4x >>> TRIG_FRAC);
        r_z4 <= B_W'(n_s4z >>> TRIG_FRAC);
    end

    // stage 5: Z rotation products
    logic signed [B_W-1:0]  r_z5;
    logic signed [P3_W-1:0] r_p5a, r_p5b, r_p5c, r_p5d;
    always_ff @(posedge i_clk) begin
        r_z5  <= r_z4;
        r_p5a <= P3_W'(r_x4) * P3_W'(zc);
        r_p5b <= P3_W'(r_y4) * P3_W'(zs);
        r_p5c <= P3_W'(r_y4) * P3_W'(zc);
        r_p5d <= P3_W'(r_x4) * P3_W'(zs);
    end

    // stage 6: Z rotation round
    logic signed [S3_W-1:0] n_s6x, n_s6y;
    logic signed [C_W-1:0]  r_x6, r_y6, r_z6;
    assign n_s6x = S3_W'(r_p5a) - S3_W'(r_p5b) + (S3_W'(1) <<< (TRIG_FRAC - 1));
    assign n_s6y = S3_W'(r_p5c) + S3_W'(r_p5d) + (S3_W'(1) <<< (TRIG_FRAC - 1));
    always_ff @(posedge i_clk) begin
        r_x6 <= C_W'(n_s6x >>> TRIG_FRAC);
        r_y6 <= C_W'(n_s6y >>> TRIG_FRAC);
        r_z6 <= C_W'(r_z5);
    end

    // stage 7: scale products
    logic signed [P4_W-1:0] r_p7x, r_p7y, r_p7z;
    always_ff @(posedge i_clk) begin
        r_p7x <= P4_W'(r_x6) * P4_W'(scale_s);
        r_p7y <= P4_W'(r_y6) * P4_W'(scale_s);
        r_p7z <= P4_W'(r_z6) * P4_W'(scale_s);
    end

    // stage 8: round and offset
    function automatic logic signed [CW-1:0] off_conv(input logic signed [TRIG_W-1:0] o);
        logic signed [CW-1:0] e;
        e = CW'(o);
        return (FRAC_BITS >= OFF_FRAC) ? (e <<< OFF_SH_L) : (e >>> OFF_SH_R);
    endfunction

    function automatic logic signed [CW-1:0] scale_round(input logic signed [P4_W-1:0] p);
        logic signed [P4_W-1:0] t;
        t = p + (P4_W'(1) <<< (SCALE_FRAC - 1));
        return CW'(t >>> SCALE_FRAC);
    endfunction

    logic signed [CW-1:0] r_x8, r_y8, r_z8;
    always_ff @(posedge i_clk) begin
        r_x8 <= scale_round(r_p7x) + off_conv(off_x);
        r_y8 <= scale_round(r_p7y) + off_conv(off_y);
        r_z8 <= scale_round(r_p7z) + off_conv(off_z);
    end

    // stage 9: depth product and magnitudes
    logic signed [PD_W-1:0] r_pd9;
    logic [CW-1:0]          r_mx9, r_mz9;
    logic                   r_sx9, r_sz9;
    always_ff @(posedge i_clk) begin
        r_pd9 <= PD_W'(r_y8) * PD_W'(gain);
        r_mx9 <= r_x8[CW-1] ? CW'(-r_x8) : CW'(r_x8);
        r_mz9 <= r_z8[CW-1] ? CW'(-r_z8) : CW'(r_z8);
        r_sx9 <= r_x8[CW-1];
        r_sz9 <= r_z8[CW-1];
    end

    // stage 10: divisor and numerator products
    logic signed [DW-1:0] r_d10;
    logic [NM_W-1:0]      r_nx10, r_nz10;
    logic                 r_sx10, r_sz10;
    always_ff @(posedge i_clk) begin
        r_d10  <= DW'(r_pd9) + D_ONE;
        r_nx10 <= NM_W'(r_mx9) * NM_W'(r_half[15:0]);
        r_nz10 <= NM_W'(r_mz9) * NM_W'(r_half[31:16]);
        r_sx10 <= r_sx9;
        r_sz10 <= r_sz9;
    end

    // stage 11: divisor magnitude and result signs
    logic [DMW-1:0] r_dm11;
    logic [NM_W-1:0] r_nx11, r_nz11;
    t_div_tag       r_tx11, r_tz11;
    always_ff @(posedge i_clk) begin
        r_dm11      <= r_d10[DW-1] ? DMW'(-r_d10) : DMW'(r_d10);
        r_nx11      <= r_nx10;
        r_nz11      <= r_nz10;
        r_tx11.neg  <= r_sx10 ^ r_d10[DW-1];
        r_tx11.zero <= (r_d10 == '0);
        r_tx11.half <= r_half[15:0];
        r_tz11.neg  <= r_sz10 ^ r_d10[DW-1];
        r_tz11.zero <= (r_d10 == '0);
        r_tz11.half <= r_half[31:16];
    end

    // stage 12: hold for divider entry
    logic [DMW-1:0]  r_dm12;
    logic [NW-1:0]   r_nx12, r_nz12;
    t_div_tag        r_tx12, r_tz12;
    always_ff @(posedge i_clk) begin
        r_dm12 <= r_dm11;
        r_nx12 <= {r_nx11, {TRIG_FRAC{1'b0}}};
        r_nz12 <= {r_nz11, {TRIG_FRAC{1'b0}}};
        r_tx12 <= r_tx11;
        r_tz12 <= r_tz11;
    end

    logic            dx_vld, dz_vld, dx_ov, dz_ov;
    logic [QB-1:0]   dx_q, dz_q;
    t_div_tag        dx_tag, dz_tag;

    prs_div #(.N_W(NW), .D_W(DMW), .Q_W(QB)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[12]),
        .i_num   (r_nx12),
        .i_den   (r_dm12),
        .i_tag   (r_tx12),
        .o_valid (dx_vld),
        .o_ov    (dx_ov),
        .o_q     (dx_q),
        .o_tag   (dx_tag)
    );

    prs_div #(.N_W(NW), .D_W(DMW), .Q_W(QB)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[12]),
        .i_num   (r_nz12),
        .i_den   (r_dm12),
        .i_tag   (r_tz12),
        .o_valid (dz_vld),
        .o_ov    (dz_ov),
        .o_q     (dz_q),
        .o_tag   (dz_tag)
    );

    // final stage: screen mapping and saturation
    logic [SCR_W:0] n_mx, n_mz;
    logic           n_zero, n_vld;
    assign n_mx   = screen_map(dx_ov, dx_tag.neg, dx_q, dx_tag.half);
    assign n_mz   = screen_map(dz_ov, dz_tag.neg, dz_q, dz_tag.half);
    assign n_zero = dx_tag.zero || dz_tag.zero;
    assign n_vld  = dx_vld && dz_vld;

    logic                  r_done, r_zero, r_clip;
    logic [SCR_W-1:0]      r_sx, r_sy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_zero <= 1'b0;
            r_clip <= 1'b0;
        end else begin
            r_done <= n_vld;
            r_zero <= n_vld && n_zero;
            r_clip <= n_vld && !n_zero && (n_mx[SCR_W] || n_mz[SCR_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx <= n_zero ? SCR_W'(SCR_MIN) : n_mx[SCR_W-1:0];
        r_sy <= n_zero ? SCR_W'(SCR_MIN) : n_mz[SCR_W-1:0];
    end

    assign o_done         = r_done;
    assign o_screen_x     = $signed(r_sx);
    assign o_screen_y     = $signed(r_sy);
    assign o_zero_divisor = r_zero;
    assign o_clipped      = r_clip;

endmodule

/* rtl/prs_chk.sv */
// Port-level checks for point_rotate_scale_project, bound to the top level.
// Depends on prs_pkg and point_rotate_scale_project_macros.svh.
`include "point_rotate_scale_project_macros.svh"
module prs_chk
    import prs_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_start,
    input logic                    o_busy,
    input logic                    o_done,
    input logic signed [SCR_W-1:0] o_screen_x,
    input logic signed [SCR_W-1:0] o_screen_y,
    input logic                    o_zero_divisor,
    input logic                    o_clipped
);

    `PRS_ASSERT_IMPL(a_start_done, i_clk, i_rst_n, i_start && !o_busy, ##PIPE_LAT o_done)
    `PRS_ASSERT_IMPL(a_done_start, i_clk, i_rst_n, o_done, $past(i_start && !o_busy, PIPE_LAT))
    `PRS_ASSERT_IMPL(a_zero_sat, i_clk, i_rst_n, o_zero_divisor, o_screen_x == SCR_W'(SCR_MIN) && o_screen_y == SCR_W'(SCR_MIN) && !o_clipped)
    `PRS_ASSERT_ALWAYS(a_flags_strobe, i_clk, i_rst_n, o_done || (!o_zero_divisor && !o_clipped))

endmodule

bind point_rotate_scale_project prs_chk u_prs_chk (.*);
